// File: sv/rnri_pkg.sv
// shared constants and types for the rtp nack retransmit index
package rnri_pkg;

  localparam int SLOTS_DEF = 256;

  localparam logic [7:0]  NACK_PT          = 8'd205;
  localparam logic [4:0]  FMT_MASK         = 5'h1F;
  localparam logic [4:0]  FMT_GENERIC_NACK = 5'd1;
  localparam logic [15:0] MIN_RTP_LEN      = 16'd12;
  localparam int          BLP_BITS         = 16;
  // pid itself plus one per loss-mask bit
  localparam int          NACK_CANDS       = BLP_BITS + 1;
  localparam int          CAND_W           = $clog2(NACK_CANDS + 1);

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_NACK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_STORED   = 2'd0,
    KIND_RESEND   = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_LOOK,
    S_FLUSH
  } state_t;

endpackage

// File: sv/rtp_nack_retransmit_index_unit.sv
// top level: slot index for an rtp retransmit buffer answering generic nack
// order: a runt is rejected at once; a store waits on the remainder unit (which also passes
//   busy_r if SLOTS is not a power of two); a nack does 17 tag reads pipelined through one ram read port
// flow: one item in flight, next word taken once its last result is queued;
//   output stalls hold the item back
// reset: synchronous active-low, then a clearing pass over every slot with in_stall high
module rtp_nack_retransmit_index_unit
  import rnri_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_sequence_req,
  input  logic [15:0] in_packet_length,
  input  logic [7:0]  in_packet_type,
  input  logic [4:0]  in_feedback_format,
  input  logic [15:0] in_lost_mask,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_slot,
  output logic [15:0] out_sequence_out,
  output logic        out_last
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOTS - 1);
  // ram word: {valid, tag}
  localparam int WORD_W = 17;

  state_t state_r, state_nxt;

  // candidate about to be issued to the ram
  logic [15:0]         want_r, want_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [CAND_W-1:0]   k_r, k_nxt;
  logic [NACK_CANDS-1:0] act_sh_r, act_sh_nxt;
  logic                act_r, act_nxt;

  // candidate whose read data is back this cycle
  logic                cmp_v_r, cmp_v_nxt;
  logic                cmp_act_r, cmp_act_nxt;
  logic [15:0]         cmp_want_r, cmp_want_nxt;
  logic [SLOT_W-1:0]   cmp_slot_r, cmp_slot_nxt;

  // one result held back so the final hit can carry last
  logic                pend_v_r, pend_v_nxt;
  kind_t               pend_kind_r, pend_kind_nxt;
  logic [7:0]          pend_slot_r, pend_slot_nxt;
  logic [15:0]         pend_seq_r, pend_seq_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r;
  logic [7:0]          out_slot_r;
  logic [15:0]         out_seq_r;
  logic                out_last_r;
  logic                out_push;
  logic                out_push_last;
  logic                out_free;

  logic [SLOT_W-1:0]   clr_cnt_r, clr_cnt_nxt;

  // ram and remainder unit hookup
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [WORD_W-1:0]   ram_rdata;
  logic                mod_start;
  logic                mod_done;
  logic [SLOT_W-1:0]   mod_rem;

  logic                hit;
  logic                block;
  logic [SLOT_W-1:0]   slot_step;

  rnri_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  rnri_mod #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (in_sequence_req),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // slot of want+1: wraps to 0 on the 16-bit sequence wrap or at the last slot
  assign slot_step = (want_r == 16'hFFFF || slot_r == SLOT_MAX) ? '0 : slot_r + 1'b1;

  assign hit   = cmp_v_r && cmp_act_r && ram_rdata[16] && (ram_rdata[15:0] == cmp_want_r);
  // a second hit with the held one unable to leave: freeze the loop,
  // the ram output register keeps its data since no read is issued
  assign block = hit && pend_v_r && !out_free;

  always_comb begin
    state_nxt     = state_r;
    want_nxt      = want_r;
    slot_nxt      = slot_r;
    k_nxt         = k_r;
    act_sh_nxt    = act_sh_r;
    act_nxt       = act_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_act_nxt   = cmp_act_r;
    cmp_want_nxt  = cmp_want_r;
    cmp_slot_nxt  = cmp_slot_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_slot_nxt = pend_slot_r;
    pend_seq_nxt  = pend_seq_r;
    clr_cnt_nxt   = clr_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    mod_start     = 1'b0;
    out_push      = 1'b0;
    out_push_last = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SLOT_MAX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          want_nxt   = in_sequence_req;
          act_sh_nxt = {in_lost_mask, 1'b1};
          act_nxt    = in_action;
          if (in_action == ACT_STORE) begin
            if (in_packet_length < MIN_RTP_LEN) begin
              // runt packet: report and leave the table alone
              pend_v_nxt    = 1'b1;
              pend_kind_nxt = KIND_REJECTED;
              pend_slot_nxt = '0;
              pend_seq_nxt  = in_sequence_req;
              state_nxt     = S_FLUSH;
            end else begin
              mod_start = 1'b1;
              state_nxt = S_MOD;
            end
          end else if (in_packet_type == NACK_PT &&
                       (in_feedback_format & FMT_MASK) == FMT_GENERIC_NACK) begin
            mod_start = 1'b1;
            state_nxt = S_MOD;
          end
          // other feedback is dropped without a result
        end
      end

      S_MOD: begin
        if (mod_done) begin
          if (act_r == ACT_STORE) begin
            ram_we        = 1'b1;
            ram_waddr     = mod_rem;
            ram_wdata     = {1'b1, want_r};
            pend_v_nxt    = 1'b1;
            pend_kind_nxt = KIND_STORED;
            pend_slot_nxt = 8'(mod_rem);
            pend_seq_nxt  = want_r;
            state_nxt     = S_FLUSH;
          end else begin
            slot_nxt  = mod_rem;
            k_nxt     = '0;
            cmp_v_nxt = 1'b0;
            state_nxt = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        if (!block) begin
          if (hit) begin
            out_push      = pend_v_r;
            pend_v_nxt    = 1'b1;
            pend_kind_nxt = KIND_RESEND;
            pend_slot_nxt = 8'(cmp_slot_r);
            pend_seq_nxt  = cmp_want_r;
          end
          if (k_r != CAND_W'(NACK_CANDS)) begin
            // issue next candidate while comparing the previous one
            ram_re       = 1'b1;
            cmp_v_nxt    = 1'b1;
            cmp_act_nxt  = act_sh_r[0];
            cmp_want_nxt = want_r;
            cmp_slot_nxt = slot_r;
            act_sh_nxt   = act_sh_r >> 1;
            want_nxt     = want_r + 16'd1;
            slot_nxt     = slot_step;
            k_nxt        = k_r + 1'b1;
          end else begin
            cmp_v_nxt = 1'b0;
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_push      = 1'b1;
          out_push_last = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_push) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      k_r         <= '0;
      cmp_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      k_r         <= k_nxt;
      cmp_v_r     <= cmp_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    want_r      <= want_nxt;
    slot_r      <= slot_nxt;
    act_sh_r    <= act_sh_nxt;
    act_r       <= act_nxt;
    cmp_act_r   <= cmp_act_nxt;
    cmp_want_r  <= cmp_want_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_seq_r  <= pend_seq_nxt;
    if (out_push) begin
      out_kind_r <= pend_kind_r;
      out_slot_r <= pend_slot_r;
      out_seq_r  <= pend_seq_r;
      out_last_r <= out_push_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_slot         = out_slot_r;
  assign out_sequence_out = out_seq_r;
  assign out_last         = out_last_r;

  // no word taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> in_stall)
    else $error("input taken during clearing pass");

  // store results are single and so always marked last
  a_store_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != KIND_RESEND |-> out_last_r)
    else $error("store result without last");

  // a held result never survives into idle
  a_pend_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("held result lost at end of item");

  // remainder unit only answers while it is awaited
  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_MOD)
    else $error("remainder done outside wait state");

  // a blocked loop holds its candidate
  a_block_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK && block |=> $stable(k_r) && $stable(cmp_want_r))
    else $error("lookup advanced while blocked");

endmodule

// File: sv/rnri_ram.sv
// generic single-port-write, registered-read ram
module rnri_ram #(
  parameter int WIDTH  = 17,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/rnri_mod.sv
// sequence number to slot index: remainder by the slot count
module rnri_mod
  import rnri_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       value,
  output logic              done,
  output logic [SLOT_W-1:0] rem
);

  localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;

  logic              done_r;
  logic [SLOT_W-1:0] rem_r;

  generate
    if (IS_POW2) begin : g_mask
      // power of two: remainder is the low bits
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          rem_r <= value[SLOT_W-1:0];
        end
      end
    end else begin : g_recip
      // quotient by reciprocal multiply on start, remainder registered in the cycle after
      // scale of 2^(16+SLOT_W) keeps the quotient exact for any 16-bit value
      localparam int          SHIFT   = 16 + SLOT_W;
      localparam logic [16:0] RECIP   = 17'(((64'd1 << SHIFT) / SLOTS) + 1);
      localparam logic [16:0] DIVISOR = 17'(SLOTS);

      logic              busy_r;
      logic [15:0]       val_r;
      logic [15:0]       quot_r;
      logic [32:0]       prod;
      logic [32:0]       back;
      logic [15:0]       quot_nxt;
      logic [SLOT_W-1:0] rem_nxt;

      always_comb begin
        prod     = {17'd0, value} * {16'd0, RECIP};
        quot_nxt = 16'(prod >> SHIFT);
        back     = {17'd0, quot_r} * {16'd0, DIVISOR};
        rem_nxt  = SLOT_W'({17'd0, val_r} - back);
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
        end else begin
          busy_r <= start;
          done_r <= busy_r;
        end
        if (start) begin
          val_r  <= value;
          quot_r <= quot_nxt;
        end
        if (busy_r) begin
          rem_r <= rem_nxt;
        end
      end
    end
  endgenerate

  assign done = done_r;
  assign rem  = rem_r;

endmodule
